// ===== hw/rtl/cle_pkg.sv =====
`timescale 1ns / 1ps

package cle_pkg;

    // Fixed field widths.
    localparam int BYTE_W = 8;
    localparam int CNT_W  = 6;

    // Result kinds.
    typedef enum logic [2:0] {
        KIND_ECHO      = 3'd0,
        KIND_ERASE     = 3'd1,
        KIND_LINE_BYTE = 3'd2,
        KIND_LINE_END  = 3'd3,
        KIND_BREAK     = 3'd4
    } kind_t;

    // Sequencer states.
    typedef enum logic [3:0] {
        S_IDLE,
        S_CHAR,
        S_BRK,
        S_CR,
        S_LF,
        S_RD,
        S_BYTE,
        S_END,
        S_ERASE,
        S_WRD,
        S_WEM
    } state_t;

    // Operations of the shared step unit.
    typedef enum logic {
        ALU_INC,
        ALU_DEC
    } alu_op_t;

    typedef struct packed {
        alu_op_t          op;
        logic [CNT_W-1:0] a;
        logic [CNT_W-1:0] b;
    } alu_req_t;

    typedef struct packed {
        logic [CNT_W-1:0] y;
        logic             eq_b;
        logic             zero;
    } alu_rsp_t;

    // Console control bytes.
    localparam logic [BYTE_W-1:0] CH_CR    = 8'h0D;
    localparam logic [BYTE_W-1:0] CH_LF    = 8'h0A;
    localparam logic [BYTE_W-1:0] CH_ETX   = 8'h03;
    localparam logic [BYTE_W-1:0] CH_NAK   = 8'h15;
    localparam logic [BYTE_W-1:0] CH_ETB   = 8'h17;
    localparam logic [BYTE_W-1:0] CH_BS    = 8'h08;
    localparam logic [BYTE_W-1:0] CH_DEL   = 8'h7F;
    localparam logic [BYTE_W-1:0] CH_BEL   = 8'h07;
    localparam logic [BYTE_W-1:0] CH_SPACE = 8'h20;

endpackage

// ===== hw/rtl/console_line_editor.sv =====
`timescale 1ns / 1ps

// Console line editor.
// The input channel (in_valid/in_ready/rx_byte) takes one received console byte
// per beat. The output channel (out_valid/out_ready) delivers result beats:
// kind, out_byte, line_length and last, where last marks the final beat caused
// by an input byte. A byte that causes no result (an erase on an empty line)
// is taken in its accepting cycle and leaves the input ready for the next byte.
// A taken byte is held in the sequencer, which loads its results into the
// output register whenever that register can take a new beat. For Enter, each
// stored byte is fetched through the single registered read port of the line
// store before it is sent. Word and line erase send one erase beat per removed
// character. One byte is handled at a time; in_ready is low until its last
// result has been loaded into the output register.
// Reset empties the line; the line store itself is not cleared, since only
// written entries are ever read back. When the receiver stalls, the output
// register holds its beat and the sequencer waits without losing work.
module console_line_editor #(
    parameter int LINE_BUFFER_SIZE = 32
) (
    input  logic                       clk,
    input  logic                       rst_n,
    input  logic                       in_valid,
    output logic                       in_ready,
    input  logic [cle_pkg::BYTE_W-1:0] rx_byte,
    output logic                       out_valid,
    input  logic                       out_ready,
    output logic [2:0]                 kind,
    output logic [cle_pkg::BYTE_W-1:0] out_byte,
    output logic [cle_pkg::CNT_W-1:0]  line_length,
    output logic                       last
);
    import cle_pkg::*;

    localparam int               AW        = $clog2(LINE_BUFFER_SIZE);
    localparam logic [CNT_W-1:0] MAX_CHARS = CNT_W'(LINE_BUFFER_SIZE - 2);

    state_t            state_reg, state_next;
    logic [CNT_W-1:0]  count_reg, count_next;
    logic [CNT_W-1:0]  idx_reg, idx_next;
    logic [BYTE_W-1:0] byte_reg, byte_next;

    logic              out_valid_reg, out_valid_next;
    kind_t             kind_reg, kind_next;
    logic [BYTE_W-1:0] out_byte_reg, out_byte_next;
    logic [CNT_W-1:0]  len_reg, len_next;
    logic              last_reg, last_next;

    logic              load_ok;
    logic              emit;
    kind_t             e_kind;
    logic [BYTE_W-1:0] e_byte;
    logic [CNT_W-1:0]  e_len;
    logic              e_last;

    logic              mem_we;
    logic [AW-1:0]     mem_waddr;
    logic [AW-1:0]     mem_raddr;
    logic [BYTE_W-1:0] mem_rdata;

    alu_req_t          alu_req;
    alu_rsp_t          alu_rsp;

    // Line store.
    cle_line_mem #(
        .DEPTH (LINE_BUFFER_SIZE)
    ) u_mem (
        .clk   (clk),
        .we    (mem_we),
        .waddr (mem_waddr),
        .wdata (byte_reg),
        .raddr (mem_raddr),
        .rdata (mem_rdata)
    );

    // Shared step unit for count and index updates.
    cle_step_alu u_alu (
        .req (alu_req),
        .rsp (alu_rsp)
    );

    // The output register can take a new beat when empty or being drained.
    assign load_ok  = !out_valid_reg || out_ready;
    assign in_ready = (state_reg == S_IDLE);

    // Sequencer: next state and result generation.
    always_comb
    begin
        state_next = state_reg;
        count_next = count_reg;
        idx_next   = idx_reg;
        byte_next  = byte_reg;
        emit       = 1'b0;
        e_kind     = KIND_ECHO;
        e_byte     = '0;
        e_len      = '0;
        e_last     = 1'b0;
        mem_we     = 1'b0;
        mem_waddr  = count_reg[AW-1:0];
        mem_raddr  = idx_reg[AW-1:0];
        alu_req    = '{op: ALU_INC, a: idx_reg, b: count_reg};

        unique case (state_reg)
            S_IDLE:
            begin
                if (in_valid)
                begin
                    byte_next = rx_byte;
                    unique case (rx_byte)
                        CH_CR, CH_LF:
                            state_next = S_CR;
                        CH_ETX:
                            state_next = S_BRK;
                        CH_NAK, CH_BS, CH_DEL:
                            state_next = (count_reg == '0) ? S_IDLE : S_ERASE;
                        CH_ETB:
                            state_next = (count_reg == '0) ? S_IDLE : S_WRD;
                        default:
                            state_next = S_CHAR;
                    endcase
                end
            end

            S_CHAR:
            begin
                alu_req = '{op: ALU_INC, a: count_reg, b: count_reg};
                if (load_ok)
                begin
                    emit       = 1'b1;
                    e_kind     = KIND_ECHO;
                    e_last     = 1'b1;
                    state_next = S_IDLE;
                    if (count_reg < MAX_CHARS)
                    begin
                        e_byte     = byte_reg;
                        mem_we     = 1'b1;
                        count_next = alu_rsp.y;
                    end
                    else
                    begin
                        e_byte = CH_BEL;
                    end
                end
            end

            S_BRK:
            begin
                if (load_ok)
                begin
                    emit       = 1'b1;
                    e_kind     = KIND_BREAK;
                    e_last     = 1'b1;
                    count_next = '0;
                    state_next = S_IDLE;
                end
            end

            S_CR:
            begin
                if (load_ok)
                begin
                    emit       = 1'b1;
                    e_byte     = CH_CR;
                    state_next = S_LF;
                end
            end

            S_LF:
            begin
                if (load_ok)
                begin
                    emit       = 1'b1;
                    e_byte     = CH_LF;
                    idx_next   = '0;
                    state_next = (count_reg == '0) ? S_END : S_RD;
                end
            end

            // Fetch the stored byte at the current index.
            S_RD:
            begin
                state_next = S_BYTE;
            end

            S_BYTE:
            begin
                if (load_ok)
                begin
                    emit       = 1'b1;
                    e_kind     = KIND_LINE_BYTE;
                    e_byte     = mem_rdata;
                    idx_next   = alu_rsp.y;
                    state_next = alu_rsp.eq_b ? S_END : S_RD;
                end
            end

            S_END:
            begin
                if (load_ok)
                begin
                    emit       = 1'b1;
                    e_kind     = KIND_LINE_END;
                    e_len      = count_reg;
                    e_last     = 1'b1;
                    count_next = '0;
                    state_next = S_IDLE;
                end
            end

            // Backspace removes one character; line erase repeats until empty.
            S_ERASE:
            begin
                alu_req = '{op: ALU_DEC, a: count_reg, b: count_reg};
                if (load_ok)
                begin
                    emit       = 1'b1;
                    e_kind     = KIND_ERASE;
                    count_next = alu_rsp.y;
                    e_last     = (byte_reg != CH_NAK) || alu_rsp.zero;
                    state_next = e_last ? S_IDLE : S_ERASE;
                end
            end

            // Word erase: read the character about to be removed.
            S_WRD:
            begin
                alu_req    = '{op: ALU_DEC, a: count_reg, b: count_reg};
                mem_raddr  = alu_rsp.y[AW-1:0];
                state_next = S_WEM;
            end

            // Stop after a space or when the line is empty.
            S_WEM:
            begin
                alu_req   = '{op: ALU_DEC, a: count_reg, b: count_reg};
                mem_raddr = alu_rsp.y[AW-1:0];
                if (load_ok)
                begin
                    emit       = 1'b1;
                    e_kind     = KIND_ERASE;
                    count_next = alu_rsp.y;
                    e_last     = alu_rsp.zero || (mem_rdata == CH_SPACE);
                    state_next = e_last ? S_IDLE : S_WRD;
                end
            end

            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    // Output register next values.
    always_comb
    begin
        out_valid_next = out_valid_reg;
        kind_next      = kind_reg;
        out_byte_next  = out_byte_reg;
        len_next       = len_reg;
        last_next      = last_reg;
        if (emit)
        begin
            out_valid_next = 1'b1;
            kind_next      = e_kind;
            out_byte_next  = e_byte;
            len_next       = e_len;
            last_next      = e_last;
        end
        else if (out_ready)
        begin
            out_valid_next = 1'b0;
        end
    end

    // Control registers.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            count_reg     <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            count_reg     <= count_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // Payload registers.
    always_ff @(posedge clk)
    begin
        idx_reg      <= idx_next;
        byte_reg     <= byte_next;
        kind_reg     <= kind_next;
        out_byte_reg <= out_byte_next;
        len_reg      <= len_next;
        last_reg     <= last_next;
    end

    assign out_valid   = out_valid_reg;
    assign kind        = kind_reg;
    assign out_byte    = out_byte_reg;
    assign line_length = len_reg;
    assign last        = last_reg;

    // The line never grows past its limit.
    assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= MAX_CHARS)
        else $error("line count exceeds store limit");

    // Line end and break always close the answer to a byte.
    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && (kind == KIND_LINE_END || kind == KIND_BREAK) |-> last)
        else $error("line end or break not marked last");

    // Only a line end carries a length.
    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && kind != KIND_LINE_END |-> line_length == '0)
        else $error("length set on a beat other than line end");

    // After taking a byte that causes results, the editor is busy in the next cycle.
    assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && in_ready && state_next != S_IDLE |=> !in_ready)
        else $error("editor not busy after taking a byte with results");

    // The line is empty right after a line end or break is loaded.
    assert property (@(posedge clk) disable iff (!rst_n)
        emit && (e_kind == KIND_LINE_END || e_kind == KIND_BREAK) |=> count_reg == '0)
        else $error("line not cleared after line end or break");

endmodule

// ===== hw/rtl/cle_step_alu.sv =====
`timescale 1ns / 1ps

module cle_step_alu (
    input  cle_pkg::alu_req_t req,
    output cle_pkg::alu_rsp_t rsp
);
    import cle_pkg::*;

    logic [CNT_W-1:0] y;

    // One incrementer/decrementer shared by the count and index steps.
    always_comb
    begin
        unique case (req.op)
            ALU_INC: y = req.a + CNT_W'(1);
            ALU_DEC: y = req.a - CNT_W'(1);
        endcase
    end

    // Flags for loop termination.
    assign rsp.y    = y;
    assign rsp.eq_b = (y == req.b);
    assign rsp.zero = (y == '0);

endmodule

// ===== hw/rtl/cle_line_mem.sv =====
`timescale 1ns / 1ps

module cle_line_mem #(
    parameter  int DEPTH = 32,
    localparam int AW    = $clog2(DEPTH)
) (
    input  logic                       clk,
    input  logic                       we,
    input  logic [AW-1:0]              waddr,
    input  logic [cle_pkg::BYTE_W-1:0] wdata,
    input  logic [AW-1:0]              raddr,
    output logic [cle_pkg::BYTE_W-1:0] rdata
);
    import cle_pkg::*;

    logic [BYTE_W-1:0] mem [DEPTH];
    logic [BYTE_W-1:0] rdata_reg;

    // Write port.
    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
    end

    // Registered read port.
    always_ff @(posedge clk)
    begin
        rdata_reg <= mem[raddr];
    end

    assign rdata = rdata_reg;

endmodule
